// File: hdl/two_class_ordered_queue_defines.svh
`ifndef TWO_CLASS_ORDERED_QUEUE_DEFINES_SVH
`define TWO_CLASS_ORDERED_QUEUE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TCOQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TCOQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/tcoq_pkg.sv
`default_nettype none

package tcoq_pkg;

  localparam logic [1:0] KIND_PUSH      = 2'd0;
  localparam logic [1:0] KIND_POP_OLD   = 2'd1;
  localparam logic [1:0] KIND_POP_CLASS = 2'd2;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_EMPTY = 2'd1;
  localparam logic [1:0] ERR_FULL  = 2'd2;

  localparam logic CLASS_DOG = 1'b0;
  localparam logic CLASS_CAT = 1'b1;

  // tuser widths: {item_class, kind} in, {error, out_class} out
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutUserW = 3;

  typedef struct packed {
    logic push;
    logic pop;
  } tcoq_cmd_t;

endpackage

`default_nettype wire

// File: hdl/tcoq_ram.sv
`default_nettype none

module tcoq_ram #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned ADDR_W = 4
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hdl/tcoq_ptr.sv
`default_nettype none

module tcoq_ptr #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned PTR_W  = 4,
  parameter int unsigned CNT_W  = 5
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tcoq_pkg::tcoq_cmd_t cmd_i,
  output logic      [PTR_W-1:0]  head_o,
  output logic      [PTR_W-1:0]  tail_o,
  output logic      [CNT_W-1:0]  fill_o
);

  import tcoq_pkg::*;

  localparam logic [PTR_W-1:0] LastIdx = PTR_W'(DEPTH - 1);

  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] fill_q, fill_d;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    fill_d = fill_q;
    if (cmd_i.push) begin
      tail_d = (tail_q == LastIdx) ? '0 : tail_q + PTR_W'(1);
    end
    if (cmd_i.pop) begin
      head_d = (head_q == LastIdx) ? '0 : head_q + PTR_W'(1);
    end
    fill_d = fill_q + CNT_W'(cmd_i.push) - CNT_W'(cmd_i.pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
    end
  end

  assign head_o = head_q;
  assign tail_o = tail_q;
  assign fill_o = fill_q;

endmodule

`default_nettype wire

// File: hdl/two_class_ordered_queue.sv
// Channel | Dir | tdata (low bit up)                          | tuser (low bit up)
// s_axis  | in  | item_id                                     | kind, item_class
// m_axis  | out | out_id, dog_count, cat_count, pushed_total  | out_class, error
//
// Each item is accepted in ST_IDLE and finished in ST_EXEC: the accept edge reads both
// queue heads from their synchronous memories, and ST_EXEC compares stamps, updates the
// pointers and writes the push entry while the result is registered.
// A waiting result stalls only ST_EXEC; no clearing pass after reset.
// rst_ni clears pointers, fill counts and the arrival counter at once.
`default_nettype none

`include "two_class_ordered_queue_defines.svh"

module two_class_ordered_queue #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 16,
  parameter int unsigned SEQ_BITS    = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // item_id
  input  wire logic [((ID_BITS+7)/8)*8-1:0] s_axis_tdata,
  // kind [1:0], item_class [2]
  input  wire logic [tcoq_pkg::InUserW-1:0] s_axis_tuser,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // out_id, dog_count, cat_count, pushed_total
  output logic [((ID_BITS+2*$clog2(QUEUE_DEPTH+1)+SEQ_BITS+7)/8)*8-1:0] m_axis_tdata,
  // out_class [0], error [2:1]
  output logic [tcoq_pkg::OutUserW-1:0] m_axis_tuser
);

  import tcoq_pkg::*;

  localparam int unsigned PtrW   = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EntryW = ID_BITS + SEQ_BITS;
  localparam int unsigned OutW   = ID_BITS + 2 * CntW + SEQ_BITS;
  localparam int unsigned OutDW  = ((OutW + 7) / 8) * 8;
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  typedef enum logic {ST_IDLE, ST_EXEC} state_e;

  state_e              state_q;
  logic [1:0]          kind_q;
  logic                cls_q;
  logic [ID_BITS-1:0]  id_q;
  logic [SEQ_BITS-1:0] seq_q;
  logic                m_valid_q;
  logic [ID_BITS-1:0]  out_id_q;
  logic                out_class_q;
  logic [1:0]          err_q;
  logic [CntW-1:0]     dog_cnt_q, cat_cnt_q;

  logic [PtrW-1:0]   dog_head, dog_tail, cat_head, cat_tail;
  logic [CntW-1:0]   dog_fill, cat_fill;
  logic [EntryW-1:0] dog_rdata, cat_rdata;
  tcoq_cmd_t         dog_cmd, cat_cmd;

  logic                in_fire, exec_fire;
  logic                push_ok, pop_any, pop_cls;
  logic [1:0]          err_c;
  logic [SEQ_BITS-1:0] seq_nx, stamp_diff;
  logic [ID_BITS-1:0]  pop_id;
  logic [CntW-1:0]     dog_cnt_nx, cat_cnt_nx;
  logic [EntryW-1:0]   wr_entry;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign exec_fire     = (state_q == ST_EXEC) && (!m_valid_q || m_axis_tready);

  // Entry: stamp in the low bits, id above.
  assign stamp_diff = dog_rdata[SEQ_BITS-1:0] - cat_rdata[SEQ_BITS-1:0];
  assign seq_nx     = seq_q + SEQ_BITS'(1);
  assign wr_entry   = {id_q, seq_nx};

  always_comb begin
    push_ok = 1'b0;
    pop_any = 1'b0;
    pop_cls = CLASS_DOG;
    err_c   = ERR_OK;
    case (kind_q)
      KIND_PUSH: begin
        if (((cls_q == CLASS_DOG) ? dog_fill : cat_fill) == FullCnt) begin
          err_c = ERR_FULL;
        end else begin
          push_ok = 1'b1;
        end
      end
      KIND_POP_OLD: begin
        if (dog_fill != '0 && cat_fill != '0) begin
          pop_any = 1'b1;
          // dog is older when its modular stamp difference is negative
          pop_cls = stamp_diff[SEQ_BITS-1] ? CLASS_DOG : CLASS_CAT;
        end else if (cat_fill != '0) begin
          pop_any = 1'b1;
          pop_cls = CLASS_CAT;
        end else if (dog_fill != '0) begin
          pop_any = 1'b1;
          pop_cls = CLASS_DOG;
        end else begin
          err_c = ERR_EMPTY;
        end
      end
      KIND_POP_CLASS: begin
        if (((cls_q == CLASS_DOG) ? dog_fill : cat_fill) == '0) begin
          err_c = ERR_EMPTY;
        end else begin
          pop_any = 1'b1;
          pop_cls = cls_q;
        end
      end
      default: begin
        err_c = ERR_OK;
      end
    endcase
  end

  assign pop_id = (pop_cls == CLASS_DOG) ? dog_rdata[EntryW-1:SEQ_BITS]
                                         : cat_rdata[EntryW-1:SEQ_BITS];

  assign dog_cmd.push = exec_fire && push_ok && (cls_q == CLASS_DOG);
  assign dog_cmd.pop  = exec_fire && pop_any && (pop_cls == CLASS_DOG);
  assign cat_cmd.push = exec_fire && push_ok && (cls_q == CLASS_CAT);
  assign cat_cmd.pop  = exec_fire && pop_any && (pop_cls == CLASS_CAT);

  assign dog_cnt_nx = dog_fill + CntW'(dog_cmd.push) - CntW'(dog_cmd.pop);
  assign cat_cnt_nx = cat_fill + CntW'(cat_cmd.push) - CntW'(cat_cmd.pop);

  tcoq_ptr #(.DEPTH(QUEUE_DEPTH), .PTR_W(PtrW), .CNT_W(CntW)) u_dog_ptr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (dog_cmd),
    .head_o (dog_head),
    .tail_o (dog_tail),
    .fill_o (dog_fill)
  );

  tcoq_ptr #(.DEPTH(QUEUE_DEPTH), .PTR_W(PtrW), .CNT_W(CntW)) u_cat_ptr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cat_cmd),
    .head_o (cat_head),
    .tail_o (cat_tail),
    .fill_o (cat_fill)
  );

  // Heads are read at the accept edge; no write is pending then.
  tcoq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(EntryW), .ADDR_W(PtrW)) u_dog_ram (
    .clk_i   (clk_i),
    .we_i    (dog_cmd.push),
    .waddr_i (dog_tail),
    .wdata_i (wr_entry),
    .re_i    (in_fire),
    .raddr_i (dog_head),
    .rdata_o (dog_rdata)
  );

  tcoq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(EntryW), .ADDR_W(PtrW)) u_cat_ram (
    .clk_i   (clk_i),
    .we_i    (cat_cmd.push),
    .waddr_i (cat_tail),
    .wdata_i (wr_entry),
    .re_i    (in_fire),
    .raddr_i (cat_head),
    .rdata_o (cat_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= KIND_PUSH;
      cls_q       <= CLASS_DOG;
      id_q        <= '0;
      seq_q       <= '0;
      m_valid_q   <= 1'b0;
      out_id_q    <= '0;
      out_class_q <= CLASS_DOG;
      err_q       <= ERR_OK;
      dog_cnt_q   <= '0;
      cat_cnt_q   <= '0;
    end else begin
      // drop the delivered item unless a new result replaces it
      if (m_valid_q && m_axis_tready && !exec_fire) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            kind_q  <= s_axis_tuser[1:0];
            cls_q   <= s_axis_tuser[2];
            id_q    <= s_axis_tdata[ID_BITS-1:0];
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_fire) begin
            if (push_ok) begin
              seq_q <= seq_nx;
            end
            m_valid_q   <= 1'b1;
            out_id_q    <= pop_any ? pop_id : '0;
            out_class_q <= pop_any ? pop_cls : CLASS_DOG;
            err_q       <= err_c;
            dog_cnt_q   <= dog_cnt_nx;
            cat_cnt_q   <= cat_cnt_nx;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = {err_q, out_class_q};
  assign m_axis_tdata  = {{(OutDW - OutW){1'b0}}, seq_q,
                          cat_cnt_q, dog_cnt_q, out_id_q};

  `TCOQ_ASSERT_IMPL(a_dog_ptr_fill, (dog_head == dog_tail) && (dog_fill != '0), dog_fill == FullCnt, "dog queue pointers disagree with fill count")
  `TCOQ_ASSERT_IMPL(a_cat_ptr_fill, (cat_head == cat_tail) && (cat_fill != '0), cat_fill == FullCnt, "cat queue pointers disagree with fill count")
  `TCOQ_ASSERT_NEXT(a_seq_push_only, !(exec_fire && push_ok), $stable(seq_q), "arrival counter moved without an accepted push")

endmodule

`default_nettype wire
